// File: hw/rtl/atgr_pkg.sv
// shared types, constants and widths for the ambient tint grade resolver
`timescale 1ns / 1ps
package atgr_pkg;

    localparam int FRAC_BITS = 12;
    localparam logic [15:0] ONE  = 16'(1 << FRAC_BITS);
    localparam logic [15:0] HALF = 16'(1 << (FRAC_BITS - 1));

    // rec.709 luminance weights, q0.16, they sum to 65536
    localparam logic [15:0] LUM_R = 16'd13933;
    localparam logic [15:0] LUM_G = 16'd46871;
    localparam logic [15:0] LUM_B = 16'd4732;
    localparam logic [16:0] LUM_HALF = 17'd32768;

    localparam int CH_W  = 16;  // input channel width
    localparam int OUT_W = 15;  // output channel width
    localparam int T_W   = 18;  // tint width after chroma normalization
    localparam int DIV_W = 34;  // dividend and quotient width
    localparam int DEN_W = 18;  // divisor width

    typedef enum logic [2:0] {
        REG_GRADE_ENABLE    = 3'd0,
        REG_CHROMA_ONLY     = 3'd1,
        REG_ACTOR_WEIGHT    = 3'd2,
        REG_MAX_DARKENING   = 3'd3,
        REG_MAX_BRIGHTENING = 3'd4,
        REG_GRADE_STRENGTH  = 3'd5
    } reg_index_t;

    // saturated view of the configuration registers
    typedef struct packed {
        logic        enable;
        logic        chroma;
        logic [12:0] weight;
        logic [12:0] flo;
        logic [14:0] cei;
        logic [12:0] strength;
    } cfg_t;

    // data that travels beside the divider lanes
    typedef struct packed {
        logic                neutral;
        logic                bypass;
        logic [3*T_W-1:0]    orig;
    } side_t;

endpackage

// File: hw/rtl/atgr_cfg.sv
// configuration registers with saturation of weight, rails and strength
`timescale 1ns / 1ps
module atgr_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [14:0]          cfg_data,
    output atgr_pkg::cfg_t       cfg
);

    logic        enable_reg;
    logic        chroma_reg;
    logic [12:0] weight_reg;
    logic [12:0] dark_reg;
    logic [14:0] bright_reg;
    logic [12:0] strength_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            chroma_reg   <= 1'b0;
            weight_reg   <= 13'd2048;
            dark_reg     <= 13'd0;
            bright_reg   <= 15'd32767;
            strength_reg <= 13'd4096;
        end else if (cfg_we) begin
            case (atgr_pkg::reg_index_t'(cfg_index))
                atgr_pkg::REG_GRADE_ENABLE:    enable_reg   <= cfg_data[0];
                atgr_pkg::REG_CHROMA_ONLY:     chroma_reg   <= cfg_data[0];
                atgr_pkg::REG_ACTOR_WEIGHT:    weight_reg   <= cfg_data[12:0];
                atgr_pkg::REG_MAX_DARKENING:   dark_reg     <= cfg_data[12:0];
                atgr_pkg::REG_MAX_BRIGHTENING: bright_reg   <= cfg_data;
                atgr_pkg::REG_GRADE_STRENGTH:  strength_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.enable   = enable_reg;
        cfg.chroma   = chroma_reg;
        cfg.weight   = (weight_reg > 13'(atgr_pkg::ONE)) ? 13'(atgr_pkg::ONE) : weight_reg;
        cfg.flo      = (dark_reg > 13'(atgr_pkg::ONE)) ? 13'(atgr_pkg::ONE) : dark_reg;
        cfg.cei      = (bright_reg < 15'(atgr_pkg::ONE)) ? 15'(atgr_pkg::ONE) : bright_reg;
        cfg.strength = (strength_reg > 13'(atgr_pkg::ONE)) ? 13'(atgr_pkg::ONE)
                                                           : strength_reg;
    end

endmodule

// File: hw/rtl/atgr_div.sv
// pipelined restoring divider, three lanes sharing one divisor, one bit per stage
`timescale 1ns / 1ps
module atgr_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [atgr_pkg::DIV_W-1:0]    in_num [3],
    input  logic [atgr_pkg::DEN_W-1:0]    in_den,
    input  atgr_pkg::side_t               in_side,
    output logic                          out_valid,
    output logic [atgr_pkg::DIV_W-1:0]    out_quo [3],
    output atgr_pkg::side_t               out_side
);

    localparam int NS = atgr_pkg::DIV_W + 1;

    logic                        vld_reg  [NS];
    logic [atgr_pkg::DIV_W-1:0]  nq_reg   [NS][3];
    logic [atgr_pkg::DEN_W-1:0]  rem_reg  [NS][3];
    logic [atgr_pkg::DEN_W-1:0]  den_reg  [NS];
    atgr_pkg::side_t             side_reg [NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                nq_reg[0][c]  <= in_num[c];
                rem_reg[0][c] <= '0;
            end
            den_reg[0]  <= in_den;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k < NS; k++) begin : g_step
        logic [atgr_pkg::DIV_W-1:0] nq_next  [3];
        logic [atgr_pkg::DEN_W-1:0] rem_next [3];

        always_comb begin
            logic [atgr_pkg::DEN_W:0] r2;
            logic [atgr_pkg::DEN_W:0] diff;
            logic                     ge;
            for (int c = 0; c < 3; c++) begin
                r2   = {rem_reg[k-1][c], nq_reg[k-1][c][atgr_pkg::DIV_W-1]};
                diff = r2 - {1'b0, den_reg[k-1]};
                ge   = (r2 >= {1'b0, den_reg[k-1]});
                rem_next[c] = ge ? diff[atgr_pkg::DEN_W-1:0] : r2[atgr_pkg::DEN_W-1:0];
                nq_next[c]  = {nq_reg[k-1][c][atgr_pkg::DIV_W-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int c = 0; c < 3; c++) begin
                    nq_reg[k][c]  <= nq_next[c];
                    rem_reg[k][c] <= rem_next[c];
                end
                den_reg[k]  <= den_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            out_quo[c] = nq_reg[NS-1][c];
        end
    end

endmodule

// File: hw/rtl/atgr_grade.sv
// final rail clamp, strength blend toward white and the output register
`timescale 1ns / 1ps
module atgr_grade (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  atgr_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    input  logic                          in_neutral,
    input  logic [atgr_pkg::DIV_W-1:0]    in_tint [3],
    output logic                          out_valid,
    output logic [atgr_pkg::OUT_W-1:0]    out_tint [3],
    output logic                          out_active
);

    logic                        v1_reg, v2_reg, v3_reg;
    logic                        n1_reg, n2_reg;
    logic [atgr_pkg::OUT_W-1:0]  c1_reg [3];
    logic [27:0]                 p2_reg [3];
    logic                        up2_reg [3];
    logic [atgr_pkg::OUT_W-1:0]  res_reg [3];
    logic                        act_reg;

    logic [atgr_pkg::OUT_W-1:0]  c_next [3];
    logic [atgr_pkg::OUT_W-1:0]  res_next [3];
    logic                        act_next;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (in_tint[c] < atgr_pkg::DIV_W'(cfg.flo)) begin
                c_next[c] = atgr_pkg::OUT_W'(cfg.flo);
            end else if (in_tint[c] > atgr_pkg::DIV_W'(cfg.cei)) begin
                c_next[c] = cfg.cei;
            end else begin
                c_next[c] = in_tint[c][atgr_pkg::OUT_W-1:0];
            end
        end
    end

    always_comb begin
        logic [28:0] rnd;
        logic [15:0] adj;
        logic [15:0] val;
        act_next = 1'b0;
        for (int c = 0; c < 3; c++) begin
            rnd = {1'b0, p2_reg[c]} + 29'(atgr_pkg::HALF);
            adj = 16'(rnd >> atgr_pkg::FRAC_BITS);
            val = up2_reg[c] ? (atgr_pkg::ONE + adj) : (atgr_pkg::ONE - adj);
            if (n2_reg) begin
                val = atgr_pkg::ONE;
            end
            res_next[c] = val[atgr_pkg::OUT_W-1:0];
            if (val != atgr_pkg::ONE) begin
                act_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [atgr_pkg::OUT_W-1:0] d;
        if (en) begin
            n1_reg <= in_neutral;
            n2_reg <= n1_reg;
            act_reg <= act_next;
            for (int c = 0; c < 3; c++) begin
                c1_reg[c]  <= c_next[c];
                up2_reg[c] <= (c1_reg[c] >= atgr_pkg::OUT_W'(atgr_pkg::ONE));
                d = (c1_reg[c] >= atgr_pkg::OUT_W'(atgr_pkg::ONE))
                    ? (c1_reg[c] - atgr_pkg::OUT_W'(atgr_pkg::ONE))
                    : (atgr_pkg::OUT_W'(atgr_pkg::ONE) - c1_reg[c]);
                p2_reg[c]  <= 28'(d) * 28'(cfg.strength);
                res_reg[c] <= res_next[c];
            end
        end
    end

    assign out_valid  = v3_reg;
    assign out_active = act_reg;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            out_tint[c] = res_reg[c];
        end
    end

endmodule

// File: hw/rtl/ambient_tint_grade_resolver_top.sv
// top level: blend, luminance, chroma divide, level divide and grade pipeline
`timescale 1ns / 1ps
// Fully pipelined ambient tint resolver: one item is accepted every clock while the
// output is not stalled, the pipeline being made up of the two 35-stage
// bit-per-stage dividers (chroma normalization and level scaling) plus the
// blend, luminance and grade stages around them. The whole pipeline advances
// together whenever the output register is empty or being taken, so a stall on
// m_ready holds every stage in place. Configuration is sampled live by every
// stage and should only be written while no item is in flight.
module ambient_tint_grade_resolver_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_env_valid,
    input  logic [15:0] s_actor_red,
    input  logic [15:0] s_actor_green,
    input  logic [15:0] s_actor_blue,
    input  logic [15:0] s_back_red,
    input  logic [15:0] s_back_green,
    input  logic [15:0] s_back_blue,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [14:0] m_tint_red,
    output logic [14:0] m_tint_green,
    output logic [14:0] m_tint_blue,
    output logic        m_grade_active
);

    localparam int DW = atgr_pkg::DIV_W;
    localparam int TW = atgr_pkg::T_W;

    atgr_pkg::cfg_t cfg;
    logic           en;

    atgr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic [15:0] lumw [3];
    logic [15:0] a_in [3];
    logic [15:0] b_in [3];
    assign lumw[0] = atgr_pkg::LUM_R;
    assign lumw[1] = atgr_pkg::LUM_G;
    assign lumw[2] = atgr_pkg::LUM_B;
    assign a_in[0] = s_actor_red;
    assign a_in[1] = s_actor_green;
    assign a_in[2] = s_actor_blue;
    assign b_in[0] = s_back_red;
    assign b_in[1] = s_back_green;
    assign b_in[2] = s_back_blue;

    // front stages: blend products, blend, luminance products, luminance
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic        n1_reg, n2_reg, n3_reg, n4_reg;
    logic [28:0] pa1_reg [3];
    logic [28:0] pb1_reg [3];
    logic [15:0] t2_reg  [3];
    logic [15:0] t3_reg  [3];
    logic [31:0] lp3_reg [3];
    logic [15:0] t4_reg  [3];
    logic [15:0] lum4_reg;

    logic [15:0] t2_next [3];
    logic [15:0] lum4_next;

    always_comb begin
        logic [29:0] s;
        for (int c = 0; c < 3; c++) begin
            s = 30'(pa1_reg[c]) + 30'(pb1_reg[c]) + 30'(atgr_pkg::HALF);
            t2_next[c] = s[27:12];
        end
    end

    always_comb begin
        logic [33:0] s;
        s = 34'(lp3_reg[0]) + 34'(lp3_reg[1]) + 34'(lp3_reg[2]) + 34'(atgr_pkg::LUM_HALF);
        lum4_next = s[31:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n1_reg <= !cfg.enable || !s_env_valid;
            n2_reg <= n1_reg;
            n3_reg <= n2_reg;
            n4_reg <= n3_reg;
            for (int c = 0; c < 3; c++) begin
                pa1_reg[c] <= 29'(a_in[c]) * 29'(cfg.weight);
                pb1_reg[c] <= 29'(b_in[c]) * 29'(13'(atgr_pkg::ONE) - cfg.weight);
                t2_reg[c]  <= t2_next[c];
                t3_reg[c]  <= t2_reg[c];
                lp3_reg[c] <= 32'(t2_reg[c]) * 32'(lumw[c]);
                t4_reg[c]  <= t3_reg[c];
            end
            lum4_reg <= lum4_next;
        end
    end

    // chroma normalization divide, passed around when chroma mode is off or the luminance is zero
    logic                   d1_in_valid;
    logic [DW-1:0]          d1_num [3];
    logic [DW-1:0]          d1_den_full;
    logic [atgr_pkg::DEN_W-1:0] d1_den;
    atgr_pkg::side_t        d1_side;
    logic                   d1_valid;
    logic [DW-1:0]          d1_quo [3];
    atgr_pkg::side_t        d1_oside;

    always_comb begin
        logic lum_zero;
        lum_zero       = (lum4_reg == 16'd0);
        d1_in_valid    = v4_reg;
        d1_side.neutral = n4_reg || (cfg.chroma && lum_zero);
        d1_side.bypass  = !cfg.chroma || lum_zero;
        d1_side.orig    = {TW'(t4_reg[2]), TW'(t4_reg[1]), TW'(t4_reg[0])};
        d1_den_full    = lum_zero ? DW'(1) : DW'(lum4_reg);
        d1_den         = d1_den_full[atgr_pkg::DEN_W-1:0];
        for (int c = 0; c < 3; c++) begin
            d1_num[c] = (DW'(t4_reg[c]) << atgr_pkg::FRAC_BITS) + DW'(lum4_reg >> 1);
        end
    end

    atgr_div u_div_chroma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d1_in_valid),
        .in_num    (d1_num),
        .in_den    (d1_den),
        .in_side   (d1_side),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_side  (d1_oside)
    );

    // level stages: pick tint, luminance products, level, target products
    logic          v5_reg, v6_reg, v7_reg, v8_reg;
    logic          n5_reg, n6_reg, n7_reg, n8_reg;
    logic [TW-1:0] t5_reg [3];
    logic [TW-1:0] t6_reg [3];
    logic [33:0]   lp6_reg [3];
    logic [TW-1:0] t7_reg [3];
    logic [TW-1:0] lvl7_reg;
    logic [TW-1:0] t8_reg [3];
    logic [32:0]   mp8_reg [3];
    logic [TW-1:0] lvl8_reg;

    logic [TW-1:0] t5_next [3];
    logic [TW-1:0] lvl7_next;
    logic [14:0]   target;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            t5_next[c] = d1_oside.bypass ? d1_oside.orig[c*TW +: TW] : d1_quo[c][TW-1:0];
        end
    end

    always_comb begin
        logic [35:0] s;
        s = 36'(lp6_reg[0]) + 36'(lp6_reg[1]) + 36'(lp6_reg[2]) + 36'(atgr_pkg::LUM_HALF);
        lvl7_next = s[33:16];
    end

    always_comb begin
        if (lvl7_reg < TW'(cfg.flo)) begin
            target = 15'(cfg.flo);
        end else if (lvl7_reg > TW'(cfg.cei)) begin
            target = cfg.cei;
        end else begin
            target = lvl7_reg[14:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= d1_valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n5_reg <= d1_oside.neutral;
            n6_reg <= n5_reg;
            n7_reg <= n6_reg;
            n8_reg <= n7_reg;
            for (int c = 0; c < 3; c++) begin
                t5_reg[c]  <= t5_next[c];
                t6_reg[c]  <= t5_reg[c];
                lp6_reg[c] <= 34'(t5_reg[c]) * 34'(lumw[c]);
                t7_reg[c]  <= t6_reg[c];
                t8_reg[c]  <= t7_reg[c];
                mp8_reg[c] <= 33'(t7_reg[c]) * 33'(target);
            end
            lvl7_reg <= lvl7_next;
            lvl8_reg <= lvl7_reg;
        end
    end

    // level scaling divide, passed around when the level is zero
    logic [DW-1:0]              d2_num [3];
    logic [atgr_pkg::DEN_W-1:0] d2_den;
    atgr_pkg::side_t            d2_side;
    logic                       d2_valid;
    logic [DW-1:0]              d2_quo [3];
    atgr_pkg::side_t            d2_oside;

    always_comb begin
        logic lvl_zero;
        lvl_zero        = (lvl8_reg == '0);
        d2_side.neutral = n8_reg;
        d2_side.bypass  = lvl_zero;
        d2_side.orig    = {t8_reg[2], t8_reg[1], t8_reg[0]};
        d2_den          = lvl_zero ? atgr_pkg::DEN_W'(1) : lvl8_reg;
        for (int c = 0; c < 3; c++) begin
            d2_num[c] = DW'(mp8_reg[c]) + DW'(lvl8_reg >> 1);
        end
    end

    atgr_div u_div_level (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v8_reg),
        .in_num    (d2_num),
        .in_den    (d2_den),
        .in_side   (d2_side),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_side  (d2_oside)
    );

    logic [DW-1:0]                g_tint [3];
    logic [atgr_pkg::OUT_W-1:0]   g_out  [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            g_tint[c] = d2_oside.bypass ? DW'(d2_oside.orig[c*TW +: TW]) : d2_quo[c];
        end
    end

    atgr_grade u_grade (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .cfg        (cfg),
        .in_valid   (d2_valid),
        .in_neutral (d2_oside.neutral),
        .in_tint    (g_tint),
        .out_valid  (m_valid),
        .out_tint   (g_out),
        .out_active (m_grade_active)
    );

    assign m_tint_red   = g_out[0];
    assign m_tint_green = g_out[1];
    assign m_tint_blue  = g_out[2];

`ifndef ASSERT_OFF
    // an inactive result is always exactly white
    a_inactive_white: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_grade_active |-> m_tint_red == 15'(atgr_pkg::ONE)
            && m_tint_green == 15'(atgr_pkg::ONE) && m_tint_blue == 15'(atgr_pkg::ONE))
        else $error("inactive item is not white");

    // a held output freezes the input side
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while output stalled");

    // after a stall the result is released only by the consumer
    a_stall_keeps_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("stalled item dropped");
`endif

endmodule

// File: tb/tb_ambient_tint_grade_resolver_top.sv
// testbench for the ambient tint grade resolver: directed and random items against a predictor
`timescale 1ns / 1ps
module tb_ambient_tint_grade_resolver_top;

    localparam logic [2:0] REG_UNUSED_LO = 3'd6;
    localparam logic [2:0] REG_UNUSED_HI = 3'd7;
    localparam int DRAIN_CYCLES = 100;
    localparam int STALL_LIMIT  = 5000;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic             env;
        logic [2:0][15:0] actor;
        logic [2:0][15:0] back;
    } ambient_t;

    typedef struct packed {
        logic [14:0] red;
        logic [14:0] green;
        logic [14:0] blue;
        logic        active;
    } tint_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [14:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_env_valid;
    logic [15:0] s_actor_red, s_actor_green, s_actor_blue;
    logic [15:0] s_back_red, s_back_green, s_back_blue;
    logic        m_valid;
    logic        m_ready;
    logic [14:0] m_tint_red, m_tint_green, m_tint_blue;
    logic        m_grade_active;

    // shadow of the register file
    logic        sh_enable   = 1'b0;
    logic        sh_chroma   = 1'b0;
    logic [12:0] sh_weight   = 13'd2048;
    logic [12:0] sh_dark     = 13'd0;
    logic [14:0] sh_bright   = 15'd32767;
    logic [12:0] sh_strength = 13'd4096;

    tint_t expected_tints[$];
    int    fail_count = 0;
    int    tx_idle_pct = 0;
    int    rx_idle_pct = 0;
    int    hold_token = 0;
    int    stall_cycles = 0;

    ambient_tint_grade_resolver_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_env_valid(s_env_valid),
        .s_actor_red(s_actor_red), .s_actor_green(s_actor_green),
        .s_actor_blue(s_actor_blue), .s_back_red(s_back_red),
        .s_back_green(s_back_green), .s_back_blue(s_back_blue),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_tint_red(m_tint_red), .m_tint_green(m_tint_green),
        .m_tint_blue(m_tint_blue), .m_grade_active(m_grade_active)
    );

    always #4 aclk = ~aclk;

    function automatic longint unsigned luminance(longint unsigned c[3]);
        return (c[0] * atgr_pkg::LUM_R + c[1] * atgr_pkg::LUM_G + c[2] * atgr_pkg::LUM_B
                + 32768) >> 16;
    endfunction

    function automatic longint unsigned div_half_up(longint unsigned a, longint unsigned d);
        return (a + d / 2) / d;
    endfunction

    function automatic tint_t predict_tint(ambient_t amb);
        longint unsigned t[3];
        longint unsigned one, w, lum, flo, cei, lvl, tgt, s, c;
        tint_t res;
        one = longint'(atgr_pkg::ONE);
        res = '{red: 15'(one), green: 15'(one), blue: 15'(one), active: 1'b0};
        if (!sh_enable || !amb.env)
            return res;
        w = (sh_weight > one) ? one : sh_weight;
        for (int i = 0; i < 3; i++)
            t[i] = (longint'(amb.back[i]) * (one - w) + longint'(amb.actor[i]) * w
                    + one / 2) >> atgr_pkg::FRAC_BITS;
        if (sh_chroma) begin
            lum = luminance(t);
            if (lum == 0)
                return res;  // black ambient stays neutral
            for (int i = 0; i < 3; i++)
                t[i] = div_half_up(t[i] * one, lum);
        end
        flo = (sh_dark > one) ? one : sh_dark;
        cei = (sh_bright < one) ? one : sh_bright;
        lvl = luminance(t);
        if (lvl > 0) begin
            tgt = (lvl < flo) ? flo : (lvl > cei) ? cei : lvl;
            for (int i = 0; i < 3; i++)
                t[i] = div_half_up(t[i] * tgt, lvl);
        end
        s = (sh_strength > one) ? one : sh_strength;
        for (int i = 0; i < 3; i++) begin
            c = (t[i] < flo) ? flo : (t[i] > cei) ? cei : t[i];
            if (c >= one)
                c = one + (((c - one) * s + one / 2) >> atgr_pkg::FRAC_BITS);
            else
                c = one - (((one - c) * s + one / 2) >> atgr_pkg::FRAC_BITS);
            t[i] = c;
            if (c != one)
                res.active = 1'b1;
        end
        res.red   = 15'(t[0]);
        res.green = 15'(t[1]);
        res.blue  = 15'(t[2]);
        return res;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [14:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        case (idx)
            atgr_pkg::REG_GRADE_ENABLE:    sh_enable   = value[0];
            atgr_pkg::REG_CHROMA_ONLY:     sh_chroma   = value[0];
            atgr_pkg::REG_ACTOR_WEIGHT:    sh_weight   = value[12:0];
            atgr_pkg::REG_MAX_DARKENING:   sh_dark     = value[12:0];
            atgr_pkg::REG_MAX_BRIGHTENING: sh_bright   = value[14:0];
            atgr_pkg::REG_GRADE_STRENGTH:  sh_strength = value[12:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(logic en, logic chroma, int w, int dark, int bright, int str);
        write_reg(atgr_pkg::REG_GRADE_ENABLE, 15'(en));
        write_reg(atgr_pkg::REG_CHROMA_ONLY, 15'(chroma));
        write_reg(atgr_pkg::REG_ACTOR_WEIGHT, 15'(w));
        write_reg(atgr_pkg::REG_MAX_DARKENING, 15'(dark));
        write_reg(atgr_pkg::REG_MAX_BRIGHTENING, 15'(bright));
        write_reg(atgr_pkg::REG_GRADE_STRENGTH, 15'(str));
    endtask

    // called on a falling edge, returns on a falling edge with valid still high
    task automatic send_item(ambient_t amb);
        tint_t exp_tint;
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        exp_tint = predict_tint(amb);
        s_valid       <= 1'b1;
        s_env_valid   <= amb.env;
        s_actor_red   <= amb.actor[0];
        s_actor_green <= amb.actor[1];
        s_actor_blue  <= amb.actor[2];
        s_back_red    <= amb.back[0];
        s_back_green  <= amb.back[1];
        s_back_blue   <= amb.back[2];
        do @(posedge aclk); while (!s_ready);
        expected_tints.push_back(exp_tint);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_tints.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_channel();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(255));
            2: return 16'($urandom_range(5200, 3000));
            default: return 16'd0;
        endcase
    endfunction

    function automatic ambient_t rand_ambient();
        ambient_t amb;
        amb.env = ($urandom_range(9) != 0);
        for (int i = 0; i < 3; i++) begin
            amb.actor[i] = rand_channel();
            amb.back[i]  = rand_channel();
        end
        return amb;
    endfunction

    function automatic ambient_t flat_ambient(logic env, logic [15:0] a, logic [15:0] b);
        ambient_t amb;
        amb.env = env;
        for (int i = 0; i < 3; i++) begin
            amb.actor[i] = a;
            amb.back[i]  = b;
        end
        return amb;
    endfunction

    task automatic test_reset_defaults();
        // disabled after reset, so every item comes back white
        send_item(flat_ambient(1'b1, 16'hFFFF, 16'h0000));
        send_item(rand_ambient());
        drain();
    endtask

    task automatic test_directed();
        ambient_t amb;
        apply_setting(1'b1, 1'b0, 2048, 0, 32767, 4096);
        send_item(flat_ambient(1'b0, 16'h1234, 16'h4321));  // feed not running
        send_item(flat_ambient(1'b1, 16'h0000, 16'h0000));  // zero level
        send_item(flat_ambient(1'b1, 16'hFFFF, 16'hFFFF));
        send_item(flat_ambient(1'b1, 16'h1000, 16'h1000));  // exact white
        amb = flat_ambient(1'b1, 16'h0000, 16'h0000);
        amb.actor[0] = 16'hFFFF;
        amb.back[2]  = 16'h8000;
        send_item(amb);
        drain();
        // chroma only, black ambient must stay neutral
        apply_setting(1'b1, 1'b1, 4096, 2048, 8192, 4096);
        send_item(flat_ambient(1'b1, 16'h0000, 16'h0000));
        send_item(flat_ambient(1'b1, 16'h0001, 16'h0000));
        send_item(amb);
        send_item(flat_ambient(1'b1, 16'hFFFF, 16'h0000));
        drain();
        // out-of-range rails, weight and strength saturate
        apply_setting(1'b1, 1'b0, 8191, 8191, 0, 8191);
        send_item(amb);
        send_item(flat_ambient(1'b1, 16'h0800, 16'hFFFF));
        send_item(flat_ambient(1'b1, 16'h0000, 16'h0000));
        drain();
        apply_setting(1'b1, 1'b0, 0, 4096, 4096, 0);
        send_item(amb);
        send_item(flat_ambient(1'b1, 16'hFFFF, 16'h0001));
        drain();
        // writes past the register list are dropped
        write_reg(REG_UNUSED_LO, 15'h7FFF);
        write_reg(REG_UNUSED_HI, 15'h0000);
        send_item(amb);
        send_item(flat_ambient(1'b1, 16'h2000, 16'h0400));
        drain();
    endtask

    task automatic test_random(int count, int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++)
            send_item(rand_ambient());
        drain();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_setting(1'b1, 1'b1, 1500, 1000, 12000, 3000);
        hold_token++;
        for (int n = 0; n < 230; n++)
            send_item(rand_ambient());
        drain();
    endtask

    task automatic test_random_settings();
        apply_setting(1'b1, 1'b0, 2048, 0, 32767, 4096);
        test_random(250, 14, 74);
        apply_setting(1'b1, 1'b1, 3000, 1024, 16384, 2048);
        test_random(250, 14, 74);
        apply_setting(1'b1, 1'b0, 0, 4096, 4096, 8191);
        test_random(250, 74, 14);
        apply_setting(1'b1, 1'b1, 8191, 8191, 0, 0);
        test_random(250, 74, 14);
        apply_setting(1'b0, 1'b1, 4096, 0, 32767, 4096);
        test_random(100, 0, 0);
        apply_setting(1'b1, 1'b1, 4096, 0, 32767, 4096);
        test_random(250, 0, 0);
        apply_setting(1'b1, 1'b0, 1234, 3000, 6000, 4096);
        test_random(250, 0, 0);
    endtask

    // result side: random stalls plus the occasional long hold-off
    always @(negedge aclk) begin
        static int hold_left = 0;
        static int hold_seen = 0;
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        tint_t exp_tint;
        if (aresetn && m_valid && m_ready) begin
            if (expected_tints.size() == 0) begin
                $error("unexpected item: tint %0d %0d %0d active %0d",
                       m_tint_red, m_tint_green, m_tint_blue, m_grade_active);
                fail_count++;
            end else begin
                exp_tint = expected_tints.pop_front();
                if (m_tint_red !== exp_tint.red) begin
                    $error("tint_red expected %0d got %0d", exp_tint.red, m_tint_red);
                    fail_count++;
                end
                if (m_tint_green !== exp_tint.green) begin
                    $error("tint_green expected %0d got %0d", exp_tint.green, m_tint_green);
                    fail_count++;
                end
                if (m_tint_blue !== exp_tint.blue) begin
                    $error("tint_blue expected %0d got %0d", exp_tint.blue, m_tint_blue);
                    fail_count++;
                end
                if (m_grade_active !== exp_tint.active) begin
                    $error("grade_active expected %0d got %0d",
                           exp_tint.active, m_grade_active);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = atgr_pkg::REG_GRADE_ENABLE;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_env_valid   = 1'b0;
        s_actor_red   = '0;
        s_actor_green = '0;
        s_actor_blue  = '0;
        s_back_red    = '0;
        s_back_green  = '0;
        s_back_blue   = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_defaults();
        test_directed();
        test_random_settings();
        test_backpressure();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
